// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes for the double-ended queue
// Operation codes, result status codes and the request type that moves
// between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_DUMP
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [WORD_W-1:0] value;
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when the
// read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/deq_front.sv =====
// ----------------------------------------------------------------------------
// deq_front: request intake and classification
// Decodes the kind of each request, drops unused kinds and holds decoded
// requests in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [deq_pkg::KIND_W-1:0]          in_kind_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   in_value_i,
  output logic                                cmd_valid_o,
  output deq_pkg::req_t                       cmd_o,
  input  logic                                cmd_pop_i
);
  import deq_pkg::*;

  localparam int unsigned QD  = 2;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  req_t            q_q [QD];
  logic [QAW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]  cnt_q, cnt_d;
  logic            keep;
  op_e             op;
  logic            push;
  logic            pop;

  always_comb begin
    keep = 1'b1;
    op   = OP_DUMP;
    case (in_kind_i)
      KIND_PUSH_FRONT: op = OP_PUSH_FRONT;
      KIND_PUSH_REAR:  op = OP_PUSH_REAR;
      KIND_POP_FRONT:  op = OP_POP_FRONT;
      KIND_POP_REAR:   op = OP_POP_REAR;
      KIND_DUMP:       op = OP_DUMP;
      default:         keep = 1'b0;
    endcase
  end

  assign in_stall_o  = (cnt_q == QCW'(QD));
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_pop_i;
  assign cmd_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= '{op: op, value: in_value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/deq_back.sv =====
// ----------------------------------------------------------------------------
// deq_back: ring execution and result output
// Keeps the front index and entry count, reads and writes the ring RAM, steps
// through dumps a word per cycle unless stalled; drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_back #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  deq_pkg::req_t                       cmd_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [deq_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [deq_pkg::WORD_W-1:0]   out_data_o,
  output logic                                out_last_o
);
  import deq_pkg::*;

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned AWP = AW + 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = AWP'(DEPTH);
  localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        idx_q, idx_d;

  logic                 pend_v_q, pend_v_d;
  logic [STATUS_W-1:0]  pend_status_q, res_status;
  logic [WORD_W-1:0]    pend_data_q, res_data;
  logic                 pend_last_q, res_last;
  logic                 pend_ram_q, res_ram;

  logic                 out_v_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [WORD_W-1:0]    out_data_q;
  logic                 out_last_q;

  logic                 out_ready;
  logic                 go;
  logic                 full;
  logic                 empty;
  logic [CW-1:0]        count_m1;
  logic [CW-1:0]        idx_p1;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  assign out_ready = !out_v_q || !out_stall_i;
  assign go        = cmd_valid_i && (!pend_v_q || out_ready);
  assign full      = (count_q == DEPTH_C);
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - CW'(1);
  assign idx_p1    = CW'(idx_q) + CW'(1);

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    idx_d      = idx_q;
    cmd_pop_o  = go;
    res_status = ST_DONE;
    res_data   = '0;
    res_last   = 1'b1;
    res_ram    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wrap_add(front_q, count_q[AW-1:0]);
    ram_re     = 1'b0;
    ram_raddr  = front_q;
    case (cmd_i.op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_data = cmd_i.value;
          ram_we   = go;
          count_d  = go ? count_q + CW'(1) : count_q;
          if (cmd_i.op == OP_PUSH_FRONT) begin
            ram_waddr = wrap_add(front_q, DEPTH_M1);
            front_d   = go ? ram_waddr : front_q;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_ram = 1'b1;
          ram_re  = go;
          count_d = go ? count_m1 : count_q;
          if (cmd_i.op == OP_POP_FRONT) begin
            front_d = go ? wrap_add(front_q, AW'(1)) : front_q;
          end else begin
            ram_raddr = wrap_add(front_q, count_m1[AW-1:0]);
          end
        end
      end
      OP_DUMP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_ram   = 1'b1;
          ram_re    = go;
          ram_raddr = wrap_add(front_q, idx_q);
          res_last  = (idx_p1 == count_q);
          cmd_pop_o = go && res_last;
          if (go) begin
            idx_d = res_last ? '0 : idx_p1[AW-1:0];
          end
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    pend_v_d = pend_v_q;
    if (go) begin
      pend_v_d = 1'b1;
    end else if (out_ready) begin
      pend_v_d = 1'b0;
    end
  end

  deq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (go) begin
      pend_status_q <= res_status;
      pend_data_q   <= res_data;
      pend_last_q   <= res_last;
      pend_ram_q    <= res_ram;
    end
    if (pend_v_q && out_ready) begin
      out_status_q <= pend_status_q;
      out_data_q   <= pend_ram_q ? ram_rdata : pend_data_q;
      out_last_q   <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      if (out_ready) begin
        out_v_q <= pend_v_q;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// A push or pop result passes the pending register, then the output register.
// Throughput: one push or pop per cycle while the output is not stalled; a
// dump reads the ring RAM once per stored word, one empty result if empty.
// Reset: asynchronous, active low; empties the queue, ring contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [deq_pkg::KIND_W-1:0]          in_kind_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [deq_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [deq_pkg::WORD_W-1:0]   out_data_o,
  output logic                                out_last_o
);
  import deq_pkg::*;

  logic cmd_valid;
  req_t cmd;
  logic cmd_pop;

  deq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_kind_i  (in_kind_i),
    .in_value_i (in_value_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  deq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_status_o(out_status_o),
    .out_data_o  (out_data_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the result channel and checks handshake and status consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [deq_pkg::STATUS_W-1:0]        out_status_o,
  input logic signed [deq_pkg::WORD_W-1:0]   out_data_o,
  input logic                                out_last_o
);
  import deq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o)
      && $stable(out_data_o) && $stable(out_last_o))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != ST_DONE) |-> (out_data_o == '0))
    else $error("failed request carries nonzero data");

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != ST_DONE) |-> out_last_o)
    else $error("failed request not marked last");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_status_o(out_status_o),
  .out_data_o  (out_data_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire
